// ===== hw/rtl/dklm_pkg.sv =====
package dklm_pkg;

  // key count on the input, key 0 is the raw override key
  localparam int NUM_KEYS = 5;
  localparam int DEB_KEYS = NUM_KEYS - 1;

  localparam int DEB_W   = 16;
  localparam int TIMED_W = 24;
  localparam int BLINK_W = 16;
  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 32;

  // register indexes (paddr[3:2])
  localparam logic [1:0] REG_DEBOUNCE = 2'd0;
  localparam logic [1:0] REG_TIMED    = 2'd1;
  localparam logic [1:0] REG_BLINK    = 2'd2;

  // press event bit positions (key n sits at bit n-1)
  localparam int EV_ON    = 0;
  localparam int EV_OFF   = 1;
  localparam int EV_TIMED = 2;
  localparam int EV_BLINK = 3;

  localparam logic [DEB_W-1:0]   DEB_RESET   = 16'd20;
  localparam logic [TIMED_W-1:0] TIMED_RESET = 24'd3000;
  localparam logic [BLINK_W-1:0] BLINK_RESET = 16'd1000;

  typedef enum logic [1:0] {
    MODE_OFF   = 2'd0,
    MODE_ON    = 2'd1,
    MODE_TIMED = 2'd2,
    MODE_BLINK = 2'd3
  } mode_t;

  // configuration limits shared by the datapath modules
  typedef struct packed {
    logic [DEB_W-1:0]   debounce_limit;
    logic [TIMED_W-1:0] timed_on_limit;
    logic [BLINK_W-1:0] blink_limit;
  } cfg_t;

  // led controller result for one tick
  typedef struct packed {
    logic  led;
    mode_t mode;
  } led_res_t;

endpackage

// ===== hw/rtl/dklm_debounce.sv =====
module dklm_debounce (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              advance,
  input  logic [dklm_pkg::DEB_KEYS-1:0]     key_levels,
  input  logic [dklm_pkg::DEB_W-1:0]        debounce_limit,
  output logic [dklm_pkg::DEB_KEYS-1:0]     events
);

  logic [dklm_pkg::DEB_KEYS-1:0] raw_last;
  logic [dklm_pkg::DEB_KEYS-1:0] raw_last_next;
  logic [dklm_pkg::DEB_KEYS-1:0] debounced_level;
  logic [dklm_pkg::DEB_KEYS-1:0] debounced_level_next;
  logic [dklm_pkg::DEB_KEYS-1:0] press_reported;
  logic [dklm_pkg::DEB_KEYS-1:0] press_reported_next;
  logic [dklm_pkg::DEB_W-1:0]    stable_count      [dklm_pkg::DEB_KEYS];
  logic [dklm_pkg::DEB_W-1:0]    stable_count_next [dklm_pkg::DEB_KEYS];

  // per-key lanes: restart on change, saturating count, accept after limit
  always_comb begin
    for (int k = 0; k < dklm_pkg::DEB_KEYS; k++) begin
      raw_last_next[k]        = raw_last[k];
      stable_count_next[k]    = stable_count[k];
      debounced_level_next[k] = debounced_level[k];
      press_reported_next[k]  = press_reported[k];
      events[k]               = 1'b0;
      if (!key_levels[k] != raw_last[k]) begin
        raw_last_next[k]     = !key_levels[k];
        stable_count_next[k] = '0;
      end else if (stable_count[k] != '1) begin
        stable_count_next[k] = stable_count[k] + 1'b1;
      end
      if (stable_count_next[k] > debounce_limit) begin
        debounced_level_next[k] = !key_levels[k];
      end
      if (debounced_level_next[k] && !press_reported[k]) begin
        press_reported_next[k] = 1'b1;
        events[k]              = 1'b1;
      end else if (!debounced_level_next[k]) begin
        press_reported_next[k] = 1'b0;
      end
    end
  end

  // lane state, updated once per transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      raw_last        <= '0;
      debounced_level <= '0;
      press_reported  <= '0;
      for (int k = 0; k < dklm_pkg::DEB_KEYS; k++) begin
        stable_count[k] <= '0;
      end
    end else if (advance) begin
      raw_last        <= raw_last_next;
      debounced_level <= debounced_level_next;
      press_reported  <= press_reported_next;
      for (int k = 0; k < dklm_pkg::DEB_KEYS; k++) begin
        stable_count[k] <= stable_count_next[k];
      end
    end
  end

endmodule

// ===== hw/rtl/dklm_led_ctrl.sv =====
module dklm_led_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          advance,
  input  logic [dklm_pkg::DEB_KEYS-1:0] events,
  input  logic                          key0_level,
  input  dklm_pkg::cfg_t                cfg,
  output dklm_pkg::led_res_t            res
);

  dklm_pkg::mode_t                mode_state;
  dklm_pkg::mode_t                mode_state_next;
  logic [dklm_pkg::TIMED_W-1:0]   mode_count;
  logic [dklm_pkg::TIMED_W-1:0]   mode_count_next;
  logic                           led_state;
  logic                           led_state_next;

  // mode selection, key0 override, then timer expiry
  always_comb begin
    mode_state_next = mode_state;
    led_state_next  = led_state;
    mode_count_next = (mode_count != '1) ? mode_count + 1'b1 : mode_count;

    if (events[dklm_pkg::EV_ON]) begin
      mode_state_next = dklm_pkg::MODE_ON;
      led_state_next  = 1'b1;
    end
    if (events[dklm_pkg::EV_OFF]) begin
      mode_state_next = dklm_pkg::MODE_OFF;
      led_state_next  = 1'b0;
    end
    if (events[dklm_pkg::EV_TIMED]) begin
      mode_state_next = dklm_pkg::MODE_TIMED;
      mode_count_next = '0;
      led_state_next  = 1'b1;
    end
    if (events[dklm_pkg::EV_BLINK]) begin
      mode_state_next = dklm_pkg::MODE_BLINK;
      mode_count_next = '0;
      led_state_next  = 1'b1;
    end

    if (!key0_level) begin
      led_state_next = 1'b1;
    end else if (mode_state_next == dklm_pkg::MODE_OFF) begin
      led_state_next = 1'b0;
    end

    case (mode_state_next)
      dklm_pkg::MODE_TIMED: begin
        if (mode_count_next >= cfg.timed_on_limit) begin
          mode_state_next = dklm_pkg::MODE_OFF;
          led_state_next  = 1'b0;
        end
      end
      dklm_pkg::MODE_BLINK: begin
        if (mode_count_next >= {{(dklm_pkg::TIMED_W-dklm_pkg::BLINK_W){1'b0}},
                                cfg.blink_limit}) begin
          led_state_next  = !led_state_next;
          mode_count_next = '0;
        end
      end
      default: begin
      end
    endcase
  end

  assign res.led  = led_state_next;
  assign res.mode = mode_state_next;

  // mode state
  always_ff @(posedge clk) begin
    if (rst) begin
      mode_state <= dklm_pkg::MODE_OFF;
      mode_count <= '0;
      led_state  <= 1'b0;
    end else if (advance) begin
      mode_state <= mode_state_next;
      mode_count <= mode_count_next;
      led_state  <= led_state_next;
    end
  end

endmodule

// ===== hw/rtl/debounced_keys_led_mode_control.sv =====
// Debounced key and LED mode controller. Each input transaction is one
// millisecond tick carrying the five raw active-low key levels; each tick
// gives exactly one result transaction with the LED drive, the LED mode and
// the press events of keys 1-4. One tick is accepted every clock cycle
// while the result register can drain; a tick goes through an input register,
// then the debounce lanes and mode logic, and lands in the result register, so
// with the output free its result is offered from the clock edge right after
// the one that accepts it. The block keeps accepting while a result waits,
// until both the input and result registers are full. Limits are set
// through the APB registers at 0x0 (debounce), 0x4 (timed-on) and 0x8
// (blink interval) and should be changed only while no tick is in flight.
module debounced_keys_led_mode_control (
  input  logic                              clk,
  input  logic                              rst,
  // tick input
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [dklm_pkg::NUM_KEYS-1:0]     key_levels,
  // result output
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              led_level,
  output logic [1:0]                        led_mode_now,
  output logic [dklm_pkg::DEB_KEYS-1:0]     press_events,
  // configuration
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [dklm_pkg::ADDR_W-1:0]       paddr,
  input  logic [dklm_pkg::DATA_W-1:0]       pwdata,
  output logic [dklm_pkg::DATA_W-1:0]       prdata,
  output logic                              pready
);

  dklm_pkg::cfg_t                 cfg;
  logic                           cfg_wr;
  logic                           s1_valid;
  logic [dklm_pkg::NUM_KEYS-1:0]  s1_key_levels;
  logic                           res_load;
  logic                           in_take;
  logic [dklm_pkg::DEB_KEYS-1:0]  events;
  dklm_pkg::led_res_t             led_res;

  // configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_limit <= dklm_pkg::DEB_RESET;
      cfg.timed_on_limit <= dklm_pkg::TIMED_RESET;
      cfg.blink_limit    <= dklm_pkg::BLINK_RESET;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        dklm_pkg::REG_DEBOUNCE: cfg.debounce_limit <= pwdata[dklm_pkg::DEB_W-1:0];
        dklm_pkg::REG_TIMED:    cfg.timed_on_limit <= pwdata[dklm_pkg::TIMED_W-1:0];
        dklm_pkg::REG_BLINK:    cfg.blink_limit    <= pwdata[dklm_pkg::BLINK_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      dklm_pkg::REG_DEBOUNCE:
        prdata = {{(dklm_pkg::DATA_W-dklm_pkg::DEB_W){1'b0}}, cfg.debounce_limit};
      dklm_pkg::REG_TIMED:
        prdata = {{(dklm_pkg::DATA_W-dklm_pkg::TIMED_W){1'b0}}, cfg.timed_on_limit};
      dklm_pkg::REG_BLINK:
        prdata = {{(dklm_pkg::DATA_W-dklm_pkg::BLINK_W){1'b0}}, cfg.blink_limit};
      default:
        prdata = '0;
    endcase
  end

  // flow control: result register loads when empty or being drained
  assign res_load = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !res_load;
  assign in_take  = in_valid && !in_stall;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (res_load) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_key_levels <= key_levels;
    end
  end

  // debounce lanes for keys 1-4
  dklm_debounce u_debounce (
    .clk            (clk),
    .rst            (rst),
    .advance        (res_load),
    .key_levels     (s1_key_levels[dklm_pkg::NUM_KEYS-1:1]),
    .debounce_limit (cfg.debounce_limit),
    .events         (events)
  );

  // led mode and timers
  dklm_led_ctrl u_led_ctrl (
    .clk        (clk),
    .rst        (rst),
    .advance    (res_load),
    .events     (events),
    .key0_level (s1_key_levels[0]),
    .cfg        (cfg),
    .res        (led_res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      led_level    <= led_res.led;
      led_mode_now <= led_res.mode;
      press_events <= events;
    end
  end

`ifndef SYNTH
  // led lit in off mode only through the key0 override
  assert property (@(posedge clk) disable iff (rst)
    (res_load && led_res.mode == dklm_pkg::MODE_OFF && led_res.led) |-> !s1_key_levels[0])
    else $error("led lit in off mode without key0 held");

  // a key4 press always leaves blink mode selected
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && press_events[dklm_pkg::EV_BLINK]) |->
      (led_mode_now == dklm_pkg::MODE_BLINK))
    else $error("key4 press did not select blink mode");

  // a tick waiting in the input register is not dropped
  assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !res_load) |=> (s1_valid && $stable(s1_key_levels)))
    else $error("pending tick lost from input register");
`endif

endmodule

// ===== tb/sv/debounced_keys_led_mode_control_test.sv =====
module debounced_keys_led_mode_control_test;
  timeunit 1ns;
  timeprecision 1ps;

  // no register lives at this index
  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned LONG_HOLD = 300;
  localparam int NUM_DIR = 26;

  typedef logic [dklm_pkg::NUM_KEYS-1:0] levels_t;

  typedef struct packed {
    logic                          led;
    dklm_pkg::mode_t               mode;
    logic [dklm_pkg::DEB_KEYS-1:0] events;
  } tick_result_t;

  typedef struct packed {
    levels_t      levels;
    logic         typed;
    tick_result_t res;
  } tick_row_t;

  // directed ticks, run with debounce 0, timed-on 2, blink 1
  localparam tick_row_t DIR_ROWS [NUM_DIR] = '{
    '{5'h1F, 1'b1, '{1'b0, dklm_pkg::MODE_OFF, 4'h0}},  // all released, LED dark
    '{5'h1E, 1'b1, '{1'b1, dklm_pkg::MODE_OFF, 4'h0}},  // key0 held forces LED on
    '{5'h1F, 1'b1, '{1'b0, dklm_pkg::MODE_OFF, 4'h0}},
    '{5'h1D, 1'b0, '0},
    '{5'h1D, 1'b1, '{1'b1, dklm_pkg::MODE_ON, 4'h1}},   // key1 press gives on mode
    '{5'h1F, 1'b0, '0},
    '{5'h1F, 1'b0, '0},
    '{5'h1B, 1'b0, '0},
    '{5'h1B, 1'b0, '0},
    '{5'h1F, 1'b0, '0},
    '{5'h1F, 1'b0, '0},
    '{5'h17, 1'b0, '0},
    '{5'h17, 1'b0, '0},
    '{5'h1F, 1'b0, '0},
    '{5'h1F, 1'b0, '0},
    '{5'h1F, 1'b0, '0},
    '{5'h0F, 1'b0, '0},
    '{5'h0F, 1'b0, '0},
    '{5'h1F, 1'b0, '0},
    '{5'h1F, 1'b0, '0},
    '{5'h00, 1'b0, '0},
    '{5'h00, 1'b0, '0},
    '{5'h1F, 1'b0, '0},
    '{5'h1F, 1'b0, '0},
    '{5'h01, 1'b0, '0},
    '{5'h01, 1'b0, '0}
  };

  logic                          clk = 1'b0;
  logic                          rst;
  logic                          in_valid;
  logic                          in_stall;
  levels_t                       key_levels;
  logic                          out_valid;
  logic                          out_stall;
  logic                          led_level;
  logic [1:0]                    led_mode_now;
  logic [dklm_pkg::DEB_KEYS-1:0] press_events;
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [dklm_pkg::ADDR_W-1:0]   paddr;
  logic [dklm_pkg::DATA_W-1:0]   pwdata;
  logic [dklm_pkg::DATA_W-1:0]   prdata;
  logic                          pready;

  // limit shadows
  logic [dklm_pkg::DEB_W-1:0]   cfg_debounce;
  logic [dklm_pkg::TIMED_W-1:0] cfg_timed;
  logic [dklm_pkg::BLINK_W-1:0] cfg_blink;

  // predicted key and LED state
  logic [dklm_pkg::DEB_KEYS-1:0] raw_prev;
  logic [dklm_pkg::DEB_KEYS-1:0] deb_lvl;
  logic [dklm_pkg::DEB_KEYS-1:0] press_seen;
  logic [dklm_pkg::DEB_W-1:0]    stable_cnt [dklm_pkg::DEB_KEYS];
  dklm_pkg::mode_t               mode_sh;
  logic [dklm_pkg::TIMED_W-1:0]  mode_cnt;
  logic                          led_sh;

  tick_result_t led_results_due [$];
  int unsigned  mismatch_cnt = 0;
  int unsigned  cycle_cnt = 0;
  int unsigned  send_idle_pct = 0;
  int unsigned  recv_stall_pct = 0;
  logic         long_hold = 1'b0;
  event         hold_trig;

  debounced_keys_led_mode_control u_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic bit log_mismatch();
    mismatch_cnt++;
    return mismatch_cnt <= 10;
  endfunction

  // one tick through the debounce lanes and the mode logic
  function automatic tick_result_t predict_led_tick(input levels_t levels);
    tick_result_t r;
    logic         held;
    r.events = '0;
    for (int k = 0; k < dklm_pkg::DEB_KEYS; k++) begin
      held = ~levels[k+1];
      if (held != raw_prev[k]) begin
        raw_prev[k] = held;
        stable_cnt[k] = '0;
      end else if (stable_cnt[k] != '1) begin
        stable_cnt[k] = stable_cnt[k] + 1'b1;
      end
      if (stable_cnt[k] > cfg_debounce) begin
        deb_lvl[k] = held;
      end
      if (deb_lvl[k] && !press_seen[k]) begin
        press_seen[k] = 1'b1;
        r.events[k] = 1'b1;
      end else if (!deb_lvl[k]) begin
        press_seen[k] = 1'b0;
      end
    end

    if (mode_cnt != '1) begin
      mode_cnt = mode_cnt + 1'b1;
    end

    // later keys override earlier ones
    if (r.events[dklm_pkg::EV_ON]) begin
      mode_sh = dklm_pkg::MODE_ON;
      led_sh = 1'b1;
    end
    if (r.events[dklm_pkg::EV_OFF]) begin
      mode_sh = dklm_pkg::MODE_OFF;
      led_sh = 1'b0;
    end
    if (r.events[dklm_pkg::EV_TIMED]) begin
      mode_sh = dklm_pkg::MODE_TIMED;
      mode_cnt = '0;
      led_sh = 1'b1;
    end
    if (r.events[dklm_pkg::EV_BLINK]) begin
      mode_sh = dklm_pkg::MODE_BLINK;
      mode_cnt = '0;
      led_sh = 1'b1;
    end

    // raw key0 override
    if (!levels[0]) begin
      led_sh = 1'b1;
    end else if (mode_sh == dklm_pkg::MODE_OFF) begin
      led_sh = 1'b0;
    end

    if (mode_sh == dklm_pkg::MODE_TIMED) begin
      if (mode_cnt >= cfg_timed) begin
        mode_sh = dklm_pkg::MODE_OFF;
        led_sh = 1'b0;
      end
    end else if (mode_sh == dklm_pkg::MODE_BLINK) begin
      if (mode_cnt >= {8'd0, cfg_blink}) begin
        led_sh = ~led_sh;
        mode_cnt = '0;
      end
    end

    r.led = led_sh;
    r.mode = mode_sh;
    return r;
  endfunction

  // apb write, then read back known registers
  task automatic reg_write(input logic [1:0] idx, input logic [dklm_pkg::DATA_W-1:0] data);
    logic [dklm_pkg::DATA_W-1:0] want;
    want = '0;
    for (int pass = 0; pass < 2; pass++) begin
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= (pass == 0);
      paddr   <= {idx, 2'b00};
      pwdata  <= data;
      @(negedge clk);
      penable <= 1'b1;
      do @(posedge clk); while (!pready);
      if (pass == 0) begin
        case (idx)
          dklm_pkg::REG_DEBOUNCE: cfg_debounce = data[dklm_pkg::DEB_W-1:0];
          dklm_pkg::REG_TIMED:    cfg_timed = data[dklm_pkg::TIMED_W-1:0];
          dklm_pkg::REG_BLINK:    cfg_blink = data[dklm_pkg::BLINK_W-1:0];
          default: ;
        endcase
        want = {16'd0, cfg_debounce};
        if (idx == dklm_pkg::REG_TIMED) want = {8'd0, cfg_timed};
        if (idx == dklm_pkg::REG_BLINK) want = {16'd0, cfg_blink};
      end else if (prdata !== want) begin
        if (log_mismatch())
          $display("register %0d readback: expected %h, got %h", idx, want, prdata);
      end
      @(negedge clk);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(negedge clk);
      if (idx == REG_UNUSED) break;
    end
  endtask

  // offer one tick and record its expected result once accepted
  task automatic send_tick(input levels_t levels, input logic typed,
                           input tick_result_t typed_res);
    tick_result_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    key_levels <= levels;
    do @(posedge clk); while (in_stall);
    r = predict_led_tick(levels);
    led_results_due.push_back(typed ? typed_res : r);
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (led_results_due.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // steady key patterns held for the debounce limit (at most 8) plus 1 to 8 ticks, with some bounce
  task automatic random_ticks(input int unsigned n);
    levels_t     held_lv;
    levels_t     lv;
    int unsigned run_len;
    int unsigned sent;
    sent = 0;
    held_lv = '1;
    while (sent < n) begin
      case ($urandom_range(3))
        0:       held_lv = '1;
        1:       held_lv = ~(levels_t'(1) << $urandom_range(dklm_pkg::NUM_KEYS - 1));
        default: held_lv = levels_t'($urandom_range(31));
      endcase
      run_len = (cfg_debounce > 16'd8) ? 8 : int'(cfg_debounce);
      run_len = run_len + $urandom_range(8, 1);
      for (int unsigned i = 0; i < run_len && sent < n; i++) begin
        lv = held_lv;
        if ($urandom_range(9) == 0)
          lv = lv ^ (levels_t'(1) << $urandom_range(dklm_pkg::NUM_KEYS - 1));
        send_tick(lv, 1'b0, '0);
        sent++;
      end
    end
  endtask

  task automatic run_phase(input logic [dklm_pkg::DATA_W-1:0] deb,
                           input logic [dklm_pkg::DATA_W-1:0] timed,
                           input logic [dklm_pkg::DATA_W-1:0] blink,
                           input int unsigned send_pct,
                           input int unsigned stall_pct, input logic hold,
                           input int unsigned n);
    reg_write(dklm_pkg::REG_DEBOUNCE, deb);
    reg_write(dklm_pkg::REG_TIMED, timed);
    reg_write(dklm_pkg::REG_BLINK, blink);
    send_idle_pct = send_pct;
    recv_stall_pct = stall_pct;
    if (hold) -> hold_trig;
    random_ticks(n);
    drain_results();
  endtask

  // receiver stalls
  always @(negedge clk) begin
    out_stall <= long_hold || ($urandom_range(99) < recv_stall_pct);
  end

  // long receiver hold-off so the block backs up
  initial begin
    forever begin
      @(hold_trig);
      long_hold = 1'b1;
      repeat (LONG_HOLD) @(posedge clk);
      long_hold = 1'b0;
    end
  end

  // compare each result transaction with the oldest expectation
  always @(posedge clk) begin
    tick_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (led_results_due.size() == 0) begin
        if (log_mismatch())
          $display("unexpected result: led=%0d mode=%0d events=%b",
                   led_level, led_mode_now, press_events);
      end else begin
        want = led_results_due.pop_front();
        if (led_level !== want.led || led_mode_now !== want.mode ||
            press_events !== want.events) begin
          if (log_mismatch())
            $display({"tick result: expected led=%0d mode=%0d events=%b, ",
                      "got led=%0d mode=%0d events=%b"},
                     want.led, want.mode, want.events,
                     led_level, led_mode_now, press_events);
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    rst        <= 1'b1;
    in_valid   <= 1'b0;
    key_levels <= '1;
    out_stall  <= 1'b0;
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    paddr      <= '0;
    pwdata     <= '0;

    cfg_debounce = dklm_pkg::DEB_RESET;
    cfg_timed    = dklm_pkg::TIMED_RESET;
    cfg_blink    = dklm_pkg::BLINK_RESET;
    raw_prev     = '0;
    deb_lvl      = '0;
    press_seen   = '0;
    for (int k = 0; k < dklm_pkg::DEB_KEYS; k++) stable_cnt[k] = '0;
    mode_sh      = dklm_pkg::MODE_OFF;
    mode_cnt     = '0;
    led_sh       = 1'b0;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // unused index is ignored, wide values are cut to register width
    reg_write(REG_UNUSED, 32'hFFFF_FFFF);
    reg_write(dklm_pkg::REG_DEBOUNCE, 32'hABCD_0000);
    reg_write(dklm_pkg::REG_TIMED, 32'hFF00_0002);
    reg_write(dklm_pkg::REG_BLINK, 32'h1234_0001);

    // directed ticks
    for (int i = 0; i < NUM_DIR; i++) begin
      send_tick(DIR_ROWS[i].levels, DIR_ROWS[i].typed, DIR_ROWS[i].res);
    end
    drain_results();

    // random phases over several limit settings and idling patterns
    run_phase(32'd1, 32'd5, 32'd3, 0, 0, 1'b0, 100);
    run_phase(32'd0, 32'd0, 32'd0, 83, 0, 1'b0, 100);
    run_phase(32'd3, 32'd1, 32'h0000_FFFF, 0, 83, 1'b0, 100);
    run_phase(32'd2, 32'h00FF_FFFF, 32'd2, 23, 23, 1'b0, 100);
    run_phase(32'hFFFF_FFFF, 32'd7, 32'd1, 0, 0, 1'b0, 60);
    run_phase(32'($urandom_range(3)), 32'($urandom_range(40, 1)),
              32'($urandom_range(12, 1)), 0, 0, 1'b1, 140);

    drain_results();
    repeat (4) @(negedge clk);
    if (mismatch_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/dklm_pkg.sv
hw/rtl/dklm_debounce.sv
hw/rtl/dklm_led_ctrl.sv
hw/rtl/debounced_keys_led_mode_control.sv
tb/sv/debounced_keys_led_mode_control_test.sv
